### hdl/b2da_pkg.sv
// Package for the binary to decimal ASCII converter.
// Holds the power-of-ten table, the ASCII offset and the controller/datapath structs.
// Depends on nothing.
package b2da_pkg;

   // Number of decimal positions of a 32-bit value.
   localparam int unsigned NUM_POS   = 10;
   localparam logic [5:0]  ASCII_ZERO = 6'd48;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;     // capture the input number
      logic       step;     // one restoring compare-subtract step
      logic [3:0] pos;      // decimal position, 9 down to 0
      logic [1:0] bit_idx;  // digit bit being resolved, 3 down to 0
      logic       emit;     // load the finished digit into the output stage
      logic       last;     // flag for the digit being emitted
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic digit_zero;     // the resolved digit is zero
      logic out_free;       // the output stage can take a digit this cycle
   } status_type;

   // Weight 10^pos * 2^sh, wide enough for 8 * 10^9.
   function automatic logic [33:0] pow10_weight(input logic [3:0] pos,
                                                input logic [1:0] sh);
      logic [33:0] base;
      unique case (pos)
         4'd0:    base = 34'd1;
         4'd1:    base = 34'd10;
         4'd2:    base = 34'd100;
         4'd3:    base = 34'd1000;
         4'd4:    base = 34'd10000;
         4'd5:    base = 34'd100000;
         4'd6:    base = 34'd1000000;
         4'd7:    base = 34'd10000000;
         4'd8:    base = 34'd100000000;
         4'd9:    base = 34'd1000000000;
         default: base = 34'd0;
      endcase
      return base << sh;
   endfunction

endpackage

### hdl/binary_to_decimal_ascii_core.sv
// Binary to decimal ASCII converter, top level.
// Instantiates b2da_controller and b2da_datapath; depends on b2da_pkg.
//
// Usage:
//   The req channel takes one unsigned 32-bit number per transfer. The rsp channel
//   returns its decimal digits as ASCII codes, most significant first, with no
//   leading zeros; zero gives a single '0'. rsp_last_digit marks the units digit.
//   Both channels use valid/ready; a transfer happens when both are high.
//   Each decimal position from 10^9 down to 10^0 takes four
//   compare-subtract steps of the single 34-bit subtractor that resolve the digit
//   bit by bit, and one emit step that hands the digit to the output register or skips it.
//   How soon the first digit appears depends on the number of leading zeros.
//   The output register lets the next digit be computed while the previous one
//   waits; a stalled receiver holds the controller in its emit step, nothing lost.
//   req_ready is high only while no number is being converted.
//   Reset clears the controller and the output valid; no other register is reset.
module binary_to_decimal_ascii_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_digit_char,
   output logic        rsp_last_digit
);
   import b2da_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer for positions and digit bits.
   b2da_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Remainder, digit and output register.
   b2da_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_number     (req_number),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule

### hdl/b2da_datapath.sv
// Datapath of the binary to decimal ASCII converter: remainder, digit and output stage.
// Depends on b2da_pkg.
module b2da_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            req_number,
   input  b2da_pkg::cmd_type      cmd,
   output b2da_pkg::status_type   status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [5:0]             rsp_digit_char,
   output logic                   rsp_last_digit
);
   import b2da_pkg::*;

   logic [31:0] rem_ff, rem_in;
   logic [3:0]  digit_ff, digit_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  char_ff, char_in;
   logic        last_ff, last_in;
   logic [33:0] weight;
   logic [33:0] rem_wide;
   logic [33:0] diff;
   logic        fits;

   // One restoring step: subtract the weighted power of ten when it fits.
   always_comb begin
      weight   = pow10_weight(cmd.pos, cmd.bit_idx);
      rem_wide = {2'b00, rem_ff};
      diff     = rem_wide - weight;
      fits     = (rem_wide >= weight);
   end

   // Remainder and digit registers.
   always_comb begin
      rem_in   = rem_ff;
      digit_in = digit_ff;
      if (cmd.load) begin
         rem_in = req_number;
      end else if (cmd.step) begin
         digit_in[cmd.bit_idx] = fits;
         if (fits) begin
            rem_in = diff[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      digit_ff <= digit_in;
   end

   // Output stage: holds one digit until the receiver takes the transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         char_in      = ASCII_ZERO + {2'b00, digit_ff};
         last_in      = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign status.digit_zero = (digit_ff == 4'd0);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_digit_char    = char_ff;
   assign rsp_last_digit    = last_ff;

endmodule

### hdl/b2da_controller.sv
// Controller of the binary to decimal ASCII converter: sequences positions and digit bits.
// Depends on b2da_pkg.
module b2da_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  b2da_pkg::status_type   status,
   output b2da_pkg::cmd_type      cmd
);
   import b2da_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CONV = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   localparam logic [3:0] TOP_POS = 4'(NUM_POS - 1);

   logic [1:0] state_ff, state_in;
   logic [3:0] pos_ff, pos_in;
   logic [1:0] bit_ff, bit_in;
   logic       started_ff, started_in;
   logic       show;

   // A digit is shown once a nonzero digit has appeared, and always in the units place.
   assign show = !status.digit_zero || started_ff || (pos_ff == 4'd0);

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      bit_in      = bit_ff;
      started_in  = started_ff;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      cmd.pos     = pos_ff;
      cmd.bit_idx = bit_ff;
      cmd.emit    = 1'b0;
      cmd.last    = (pos_ff == 4'd0);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load   = 1'b1;
               pos_in     = TOP_POS;
               bit_in     = 2'd3;
               started_in = 1'b0;
               state_in   = S_CONV;
            end
         end
         S_CONV: begin
            cmd.step = 1'b1;
            if (bit_ff == 2'd0) begin
               state_in = S_EMIT;
            end else begin
               bit_in = bit_ff - 2'd1;
            end
         end
         S_EMIT: begin
            if (show) begin
               if (status.out_free) begin
                  cmd.emit   = 1'b1;
                  started_in = 1'b1;
                  if (pos_ff == 4'd0) begin
                     state_in = S_IDLE;
                  end else begin
                     pos_in   = pos_ff - 4'd1;
                     bit_in   = 2'd3;
                     state_in = S_CONV;
                  end
               end
            end else begin
               // Leading zero: skip it and move to the next position.
               pos_in   = pos_ff - 4'd1;
               bit_in   = 2'd3;
               state_in = S_CONV;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pos_ff     <= 4'd0;
         bit_ff     <= 2'd0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         bit_ff     <= bit_in;
         started_ff <= started_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   // The position counter never leaves the range of a 32-bit number's digits.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= TOP_POS)
      else $error("position counter out of range");

   // A digit is handed to the output stage only after its four bits are resolved.
   a_emit_after_conv: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (state_ff == S_EMIT) && status.out_free)
      else $error("digit emitted outside the emit state");

   // An accepted number starts at the top position with the weight-eight bit.
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_CONV) && (pos_ff == TOP_POS)
                                   && (bit_ff == 2'd3) && !started_ff)
      else $error("conversion did not start at the top position");

   // The units digit always ends the run and returns the controller to idle.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> (state_ff == S_IDLE))
      else $error("run did not end after the units digit");

endmodule
